### hw/rtl/va_pkg.sv
// shared types and defaults for the 3d vector arithmetic unit
package va_pkg;

  // default component width and fraction bits (signed q16.16)
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // operation codes carried in the input tuser
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_SDIV  = 3'd3,
    OP_EMUL  = 3'd4,
    OP_EDIV  = 3'd5,
    OP_CROSS = 3'd6,
    OP_NORM  = 3'd7
  } op_t;

endpackage

### hw/rtl/vec3_arithmetic_unit_core.sv
// 3d vector alu: add, sub, scale, divide, multiply, cross, normalize, length
//
// channel | dir | handshake           | payload
// in      | in  | in_tvalid/in_tready | tdata a_x a_y a_z b_x b_y b_z, tuser opcode
// out     | out | out_tvalid/out_tready | tdata r_x r_y r_z magnitude, tuser flags
//
// one beat accepted per cycle unless the output stalls; the pipeline depth is set
// by the two root chains and the quotient chain
// reset clears every stage valid bit, which empties the pipeline
// a stall at the output freezes the whole chain, in_tready follows it
module vec3_arithmetic_unit_core
  import va_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z from the lowest bit up
  input  logic [((6*DATA_WIDTH+7)/8)*8-1:0]    in_tdata,
  // opcode
  input  logic [2:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // r_x, r_y, r_z, magnitude from the lowest bit up
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0]    out_tdata,
  // div_zero, overflow
  output logic [1:0]                           out_tuser
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int Q   = W + F;
  localparam int VW  = (2*W+1 > Q+1) ? 2*W+1 : Q+1;
  localparam int ODW = ((4*W+7)/8)*8;
  localparam int P1W = 7 + 3*VW + 3*Q + 3*W;
  localparam int P2W = 7 + 3*VW;
  localparam int P3W = 2 + 3*W;
  localparam logic signed [VW-1:0] SMAX = $signed({{(VW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [VW-1:0] SMIN = ~SMAX;

  logic en;

  // global advance: the chain moves unless a result waits
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: input capture
  logic                     v1_r;
  op_t                      op1_r;
  logic signed [2:0][W-1:0] a1_r;
  logic signed [2:0][W-1:0] b1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= op_t'(in_tuser);
      for (int i = 0; i < 3; i++) begin
        a1_r[i] <= in_tdata[i*W +: W];
        b1_r[i] <= in_tdata[(i+3)*W +: W];
      end
    end
  end

  // stage 2: operand select and products
  logic signed [W-1:0]        max_v [3];
  logic signed [W-1:0]        may_v [3];
  logic signed [W-1:0]        mbx_v [3];
  logic signed [W-1:0]        mby_v [3];
  logic                       v2_r;
  op_t                        op2_r;
  logic signed [2:0][W-1:0]   a2_r;
  logic signed [2:0][W-1:0]   b2_r;
  logic signed [2*W-1:0]      pa2_r [3];
  logic signed [2*W-1:0]      pb2_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      max_v[i] = a1_r[i];
      may_v[i] = b1_r[i];
      mbx_v[i] = '0;
      mby_v[i] = '0;
    end
    unique case (op1_r)
      OP_CROSS: begin
        max_v[0] = a1_r[1]; may_v[0] = b1_r[2]; mbx_v[0] = a1_r[2]; mby_v[0] = b1_r[1];
        max_v[1] = a1_r[2]; may_v[1] = b1_r[0]; mbx_v[1] = a1_r[0]; mby_v[1] = b1_r[2];
        max_v[2] = a1_r[0]; may_v[2] = b1_r[1]; mbx_v[2] = a1_r[1]; mby_v[2] = b1_r[0];
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) may_v[i] = b1_r[0];
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++) may_v[i] = a1_r[i];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r <= op1_r;
      a2_r  <= a1_r;
      b2_r  <= b1_r;
      for (int i = 0; i < 3; i++) begin
        pa2_r[i] <= max_v[i] * may_v[i];
        pb2_r[i] <= mbx_v[i] * mby_v[i];
      end
    end
  end

  // stage 3: direct results, dividends, divisors, radicand of a
  logic signed [2*W:0]        diff_v [3];
  logic signed [VW-1:0]       dx_v [3];
  logic [2:0][VW-1:0]         val_v;
  logic [2:0][Q-1:0]          dvd_v;
  logic [2:0][W-1:0]          dsr_v;
  logic [2:0][W-1:0]          amag_v;
  logic [2:0][W-1:0]          bmag_v;
  logic [2:0]                 qneg_v;
  logic                       dz_v;
  logic [2*W-1:0]             sum3_nxt;
  logic [P1W-1:0]             p3_nxt;
  logic                       v3_r;
  logic [2*W-1:0]             s3_r;
  logic [P1W-1:0]             p3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_v[i] = (2*W+1)'(pa2_r[i]) - (2*W+1)'(pb2_r[i]);
      dx_v[i]   = VW'(diff_v[i]);
      amag_v[i] = a2_r[i][W-1] ? W'(-a2_r[i]) : W'(a2_r[i]);
      bmag_v[i] = b2_r[i][W-1] ? W'(-b2_r[i]) : W'(b2_r[i]);
      dvd_v[i]  = {amag_v[i], {F{1'b0}}};
      val_v[i]  = '0;
      dsr_v[i]  = W'(1);
      qneg_v[i] = a2_r[i][W-1];
    end
    dz_v = 1'b0;
    unique case (op2_r) inside
      OP_ADD: begin
        for (int i = 0; i < 3; i++) val_v[i] = VW'($signed(a2_r[i])) + VW'($signed(b2_r[i]));
      end
      OP_SUB: begin
        for (int i = 0; i < 3; i++) val_v[i] = VW'($signed(a2_r[i])) - VW'($signed(b2_r[i]));
      end
      OP_SCALE, OP_EMUL, OP_CROSS: begin
        for (int i = 0; i < 3; i++) val_v[i] = dx_v[i] >>> F;
      end
      OP_SDIV: begin
        dz_v = (b2_r[0] == '0);
        for (int i = 0; i < 3; i++) begin
          dsr_v[i]  = bmag_v[0];
          qneg_v[i] = a2_r[i][W-1] ^ b2_r[0][W-1];
        end
      end
      OP_EDIV: begin
        dz_v = (b2_r[0] == '0) || (b2_r[1] == '0) || (b2_r[2] == '0);
        for (int i = 0; i < 3; i++) begin
          dsr_v[i]  = bmag_v[i];
          qneg_v[i] = a2_r[i][W-1] ^ b2_r[i][W-1];
        end
      end
      OP_NORM: begin
        dz_v = (a2_r[0] == '0) && (a2_r[1] == '0) && (a2_r[2] == '0);
      end
      default: begin
      end
    endcase
    sum3_nxt = $unsigned(pa2_r[0]) + $unsigned(pa2_r[1]) + $unsigned(pa2_r[2]);
    p3_nxt   = {op2_r, dz_v, qneg_v, val_v, dvd_v, dsr_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= sum3_nxt;
      p3_r <= p3_nxt;
    end
  end

  // root chain for the length of a
  logic             c1_v    [W+1];
  logic [W+2:0]     c1_rem  [W+1];
  logic [W-1:0]     c1_root [W+1];
  logic [2*W-1:0]   c1_rad  [W+1];
  logic [P1W-1:0]   c1_pay  [W+1];

  assign c1_v[0]    = v3_r;
  assign c1_rem[0]  = '0;
  assign c1_root[0] = '0;
  assign c1_rad[0]  = s3_r;
  assign c1_pay[0]  = p3_r;

  for (genvar k = 0; k < W; k++) begin : g_len_a
    va_sqrt_cell #(.W(W), .PW(P1W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (c1_v[k]),
      .in_rem   (c1_rem[k]),
      .in_root  (c1_root[k]),
      .in_rad   (c1_rad[k]),
      .in_pay   (c1_pay[k]),
      .out_valid(c1_v[k+1]),
      .out_rem  (c1_rem[k+1]),
      .out_root (c1_root[k+1]),
      .out_rad  (c1_rad[k+1]),
      .out_pay  (c1_pay[k+1])
    );
  end

  // hand over to the quotient chain, length as divisor for normalize
  logic [2:0]         e1_op;
  logic               e1_dz;
  logic [2:0]         e1_qneg;
  logic [2:0][VW-1:0] e1_val;
  logic [2:0][Q-1:0]  e1_dvd;
  logic [2:0][W-1:0]  e1_dsr;
  logic [2:0][W-1:0]  d0_dsr;

  assign {e1_op, e1_dz, e1_qneg, e1_val, e1_dvd, e1_dsr} = c1_pay[W];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d0_dsr[i] = (op_t'(e1_op) == OP_NORM) ? c1_root[W] : e1_dsr[i];
    end
  end

  logic               c2_v   [Q+1];
  logic [2:0][W-1:0]  c2_rem [Q+1];
  logic [2:0][Q-1:0]  c2_nq  [Q+1];
  logic [2:0][W-1:0]  c2_dsr [Q+1];
  logic [P2W-1:0]     c2_pay [Q+1];

  assign c2_v[0]   = c1_v[W];
  assign c2_rem[0] = '0;
  assign c2_nq[0]  = e1_dvd;
  assign c2_dsr[0] = d0_dsr;
  assign c2_pay[0] = {e1_op, e1_dz, e1_qneg, e1_val};

  for (genvar k = 0; k < Q; k++) begin : g_quot
    va_div_cell #(.W(W), .Q(Q), .PW(P2W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (c2_v[k]),
      .in_rem   (c2_rem[k]),
      .in_nq    (c2_nq[k]),
      .in_dsr   (c2_dsr[k]),
      .in_pay   (c2_pay[k]),
      .out_valid(c2_v[k+1]),
      .out_rem  (c2_rem[k+1]),
      .out_nq   (c2_nq[k+1]),
      .out_dsr  (c2_dsr[k+1]),
      .out_pay  (c2_pay[k+1])
    );
  end

  // stage 5: pick quotient or direct value, saturate, zero on divide by zero
  logic [2:0]           e2_op;
  logic                 e2_dz;
  logic [2:0]           e2_qneg;
  logic [2:0][VW-1:0]   e2_val;
  logic signed [VW-1:0] qv_v [3];
  logic signed [VW-1:0] sv_v [3];
  logic                 is_div;
  logic [2:0][W-1:0]    r5_nxt;
  logic                 ov5_nxt;
  logic                 v5_r;
  logic                 dz5_r;
  logic                 ov5_r;
  logic [2:0][W-1:0]    r5_r;

  assign {e2_op, e2_dz, e2_qneg, e2_val} = c2_pay[Q];

  always_comb begin
    case (op_t'(e2_op)) inside
      OP_SDIV, OP_EDIV, OP_NORM: is_div = 1'b1;
      default:                   is_div = 1'b0;
    endcase
    ov5_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      qv_v[i] = e2_qneg[i] ? -$signed(VW'(c2_nq[Q][i])) : $signed(VW'(c2_nq[Q][i]));
      sv_v[i] = is_div ? qv_v[i] : $signed(e2_val[i]);
      if (sv_v[i] > SMAX) begin
        r5_nxt[i] = SMAX[W-1:0];
        ov5_nxt   = 1'b1;
      end else if (sv_v[i] < SMIN) begin
        r5_nxt[i] = SMIN[W-1:0];
        ov5_nxt   = 1'b1;
      end else begin
        r5_nxt[i] = sv_v[i][W-1:0];
      end
    end
    if (e2_dz) begin
      r5_nxt  = '0;
      ov5_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= c2_v[Q];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r5_r  <= r5_nxt;
      ov5_r <= ov5_nxt;
      dz5_r <= e2_dz;
    end
  end

  // stage 6: squares of the result
  logic                  v6_r;
  logic                  dz6_r;
  logic                  ov6_r;
  logic [2:0][W-1:0]     r6_r;
  logic signed [2*W-1:0] sq6_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r6_r  <= r5_r;
      ov6_r <= ov5_r;
      dz6_r <= dz5_r;
      for (int i = 0; i < 3; i++) begin
        sq6_r[i] <= $signed(r5_r[i]) * $signed(r5_r[i]);
      end
    end
  end

  // stage 7: sum of squares
  logic           v7_r;
  logic [2*W-1:0] s7_r;
  logic [P3W-1:0] p7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_r <= $unsigned(sq6_r[0]) + $unsigned(sq6_r[1]) + $unsigned(sq6_r[2]);
      p7_r <= {ov6_r, dz6_r, r6_r};
    end
  end

  // root chain for the magnitude of the result
  logic             c3_v    [W+1];
  logic [W+2:0]     c3_rem  [W+1];
  logic [W-1:0]     c3_root [W+1];
  logic [2*W-1:0]   c3_rad  [W+1];
  logic [P3W-1:0]   c3_pay  [W+1];

  assign c3_v[0]    = v7_r;
  assign c3_rem[0]  = '0;
  assign c3_root[0] = '0;
  assign c3_rad[0]  = s7_r;
  assign c3_pay[0]  = p7_r;

  for (genvar k = 0; k < W; k++) begin : g_len_r
    va_sqrt_cell #(.W(W), .PW(P3W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (c3_v[k]),
      .in_rem   (c3_rem[k]),
      .in_root  (c3_root[k]),
      .in_rad   (c3_rad[k]),
      .in_pay   (c3_pay[k]),
      .out_valid(c3_v[k+1]),
      .out_rem  (c3_rem[k+1]),
      .out_root (c3_root[k+1]),
      .out_rad  (c3_rad[k+1]),
      .out_pay  (c3_pay[k+1])
    );
  end

  // result beat straight from the last cell
  logic              e3_ov;
  logic              e3_dz;
  logic [2:0][W-1:0] e3_r;

  assign {e3_ov, e3_dz, e3_r} = c3_pay[W];
  assign out_tvalid = c3_v[W];
  assign out_tdata  = ODW'({c3_root[W], e3_r});
  assign out_tuser  = {e3_ov, e3_dz};

`ifndef SYNTHESIS
  // divide by zero gives an all-zero result without overflow
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata[4*W-1:0] == '0) && !out_tuser[1])
    else $error("div_zero result not cleared");

  // length is zero exactly for the zero vector
  a_mag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[4*W-1:3*W] == '0) == (out_tdata[3*W-1:0] == '0)))
    else $error("magnitude disagrees with result vector");

  // a stall freezes the chain ends
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v1_r) && $stable(c2_v[Q]) && $stable(c3_root[W]))
    else $error("pipeline moved during stall");
`endif

endmodule

### hw/rtl/va_sqrt_cell.sv
// one step of a digit-by-digit integer square root, with a carried payload
module va_sqrt_cell
  import va_pkg::*;
#(
  parameter int W  = DATA_WIDTH_DEF,
  parameter int PW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [W+2:0]    in_rem,
  input  logic [W-1:0]    in_root,
  input  logic [2*W-1:0]  in_rad,
  input  logic [PW-1:0]   in_pay,
  output logic            out_valid,
  output logic [W+2:0]    out_rem,
  output logic [W-1:0]    out_root,
  output logic [2*W-1:0]  out_rad,
  output logic [PW-1:0]   out_pay
);

  logic [W+2:0]   rsh;
  logic [W+2:0]   trial;
  logic           ge;
  logic [W+2:0]   rem_nxt;
  logic [W-1:0]   root_nxt;
  logic [2*W-1:0] rad_nxt;

  // bring down the next two radicand bits and try a one digit
  always_comb begin
    rsh      = {in_rem[W:0], in_rad[2*W-1 -: 2]};
    trial    = (W+3)'({in_root, 2'b01});
    ge       = (rsh >= trial);
    rem_nxt  = ge ? (rsh - trial) : rsh;
    root_nxt = {in_root[W-2:0], ge};
    rad_nxt  = {in_rad[2*W-3:0], 2'b00};
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // partial root and payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_nxt;
      out_root <= root_nxt;
      out_rad  <= rad_nxt;
      out_pay  <= in_pay;
    end
  end

endmodule

### hw/rtl/va_div_cell.sv
// one restoring division step for three lanes, with a carried payload
module va_div_cell
  import va_pkg::*;
#(
  parameter int W  = DATA_WIDTH_DEF,
  parameter int Q  = DATA_WIDTH_DEF + FRAC_BITS_DEF,
  parameter int PW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0][W-1:0]   in_rem,
  input  logic [2:0][Q-1:0]   in_nq,
  input  logic [2:0][W-1:0]   in_dsr,
  input  logic [PW-1:0]       in_pay,
  output logic                out_valid,
  output logic [2:0][W-1:0]   out_rem,
  output logic [2:0][Q-1:0]   out_nq,
  output logic [2:0][W-1:0]   out_dsr,
  output logic [PW-1:0]       out_pay
);

  logic [2:0][W:0]   rsh;
  logic [2:0][W:0]   dif;
  logic [2:0]        ge;
  logic [2:0][W-1:0] rem_nxt;
  logic [2:0][Q-1:0] nq_nxt;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsh[i]     = {in_rem[i], in_nq[i][Q-1]};
      ge[i]      = (rsh[i] >= {1'b0, in_dsr[i]});
      dif[i]     = rsh[i] - {1'b0, in_dsr[i]};
      rem_nxt[i] = ge[i] ? dif[i][W-1:0] : rsh[i][W-1:0];
      nq_nxt[i]  = {in_nq[i][Q-2:0], ge[i]};
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // lane state and payload
  always_ff @(posedge clk) begin
    if (en) begin
      out_rem <= rem_nxt;
      out_nq  <= nq_nxt;
      out_dsr <= in_dsr;
      out_pay <= in_pay;
    end
  end

endmodule
